// File: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types and codes for the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Fixed field widths of the request and response transactions.
    localparam int VALUE_BITS    = 32;
    localparam int PRIO_BITS     = 8;
    localparam int COUNT_BITS    = 5;
    localparam int STATUS_BITS   = 2;

    // Request kinds.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Response status codes.
    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    // One stored entry.
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] data;
        logic        [PRIO_BITS-1:0]  prio;
    } entry_t;

    // Request transaction.
    typedef struct packed {
        logic                         req_type;
        logic signed [VALUE_BITS-1:0] item_value;
        logic        [PRIO_BITS-1:0]  item_priority;
    } req_t;

    // Response transaction.
    typedef struct packed {
        logic signed [VALUE_BITS-1:0]  popped_value;
        logic        [PRIO_BITS-1:0]   popped_priority;
        logic        [STATUS_BITS-1:0] status;
        logic signed [VALUE_BITS-1:0]  head_value;
        logic        [PRIO_BITS-1:0]   head_priority;
        logic                          queue_empty;
        logic        [COUNT_BITS-1:0]  entry_count;
    } rsp_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic   push_en;
        logic   pop_en;
        entry_t item;
    } spq_cmd_t;

endpackage

// File: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry of the sorted chain and shifts it left or right.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic     clk,
    input  spq_cmd_t cmd,
    input  logic     occupied,
    input  entry_t   left_entry,
    input  logic     left_stay,
    input  entry_t   right_entry,
    output entry_t   entry,
    output logic     stay
);

    entry_t entry_reg;
    entry_t entry_next;

    // The entry stays put on a push when it is held and does not rank behind
    // the new item; equal priorities stay ahead so ties leave in arrival order.
    assign stay  = occupied && (entry_reg.prio <= cmd.item.prio);
    assign entry = entry_reg;

    // Insert, shift right on push, or shift left on pop.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.push_en && !stay)
        begin
            entry_next = left_stay ? cmd.item : left_entry;
        end
        else if (cmd.pop_en)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: sv/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of (data, priority) entries kept sorted in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall, req) carries one push or pop per
// transaction. A push inserts the entry behind all held entries of equal or
// lower priority value; a pop removes the head. Every request gives exactly
// one response transaction on (rsp_valid, rsp_stall, rsp), which reports the
// popped entry, a status code, the head after the operation, an empty flag
// and the entry count.
// The response is registered. Throughput is one request per cycle while the
// response is not stalled: every cell compares its priority with the new item
// in parallel and shifts in the same cycle.
// The response sits in an output register; a new request is taken while that
// register is empty or being emptied, so a stalled response stalls requests.
// Reset clears the entry count and the response valid; cell contents are not
// cleared, since only cells below the count are ever read.
// A push on a full queue reports a full status and changes nothing; a pop on
// an empty queue reports an empty status and changes nothing.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic     accept;
    logic     full;
    logic     empty;
    spq_cmd_t cmd;
    entry_t   cell_entry [CAPACITY];
    logic     cell_stay  [CAPACITY];
    entry_t   head_sel;

    // Request handshake.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    // Command broadcast to the chain.
    assign cmd.push_en    = accept && (req.req_type == REQ_PUSH) && !full;
    assign cmd.pop_en     = accept && (req.req_type == REQ_POP) && !empty;
    assign cmd.item.data  = req.item_value;
    assign cmd.item.prio  = req.item_priority;

    // Row of cells; the head cell sees an always-staying left neighbour and
    // the tail cell takes filler on pop, which the count marks as unused.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            entry_t left_e;
            logic   left_s;
            entry_t right_e;

            if (gi == 0)
            begin : g_head
                assign left_e = cmd.item;
                assign left_s = 1'b1;
            end
            else
            begin : g_body
                assign left_e = cell_entry[gi-1];
                assign left_s = cell_stay[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_e = cmd.item;
            end
            else
            begin : g_inner
                assign right_e = cell_entry[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (count_reg > CNT_W'(gi)),
                .left_entry  (left_e),
                .left_stay   (left_s),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .stay        (cell_stay[gi])
            );
        end
    endgenerate

    // Entry count after the operation.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Head after the operation, taken from the values the cells will load.
    always_comb
    begin
        if (cmd.push_en)
        begin
            head_sel = cell_stay[0] ? cell_entry[0] : cmd.item;
        end
        else if (cmd.pop_en)
        begin
            head_sel = cell_entry[1];
        end
        else
        begin
            head_sel = cell_entry[0];
        end
    end

    // Response contents.
    always_comb
    begin
        rsp_next                 = '0;
        rsp_next.entry_count     = COUNT_BITS'(count_next);
        rsp_next.queue_empty     = (count_next == '0);
        if (count_next != '0)
        begin
            rsp_next.head_value    = head_sel.data;
            rsp_next.head_priority = head_sel.prio;
        end
        if (cmd.pop_en)
        begin
            rsp_next.popped_value    = cell_entry[0].data;
            rsp_next.popped_priority = cell_entry[0].prio;
        end
        if ((req.req_type == REQ_PUSH) && full)
        begin
            rsp_next.status = STATUS_FULL;
        end
        else if ((req.req_type == REQ_POP) && empty)
        begin
            rsp_next.status = STATUS_EMPTY;
        end
        else
        begin
            rsp_next.status = STATUS_OK;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: sv/spq_checker.sv
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level properties of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // A stalled response stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    // The empty flag agrees with the count.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.queue_empty == (rsp.entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    // An empty queue reports a zero head.
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.queue_empty |-> (rsp.head_value == '0) && (rsp.head_priority == '0))
        else $error("non-zero head on empty queue");

    // A rejected push only happens on a full queue.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STATUS_FULL) |->
            (rsp.entry_count == COUNT_BITS'(CAPACITY)))
        else $error("full status with queue not full");

    // A failed pop leaves an empty queue and returns nothing.
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STATUS_EMPTY) |->
            rsp.queue_empty && (rsp.popped_value == '0) && (rsp.popped_priority == '0))
        else $error("empty status with entries held or data returned");

endmodule

bind sorted_priority_queue_top spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

// File: bench/sorted_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives push and pop transactions into the sorted priority queue, keeps a
// behavioural copy of the sorted entry list, and checks every response
// transaction field by field against the predicted one. Both channels idle
// and stall at random, except for one stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_tb;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int IDLE_PERCENT  = 34;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS   = 10;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Behavioural copy of the queue, head at index zero.
    entry_t held_entries[$];
    // Responses predicted for accepted requests, oldest first.
    rsp_t   expected_reports[$];
    int     error_count = 0;
    bit     steady_run  = 1'b0;

    sorted_priority_queue_top #(
        .CAPACITY (QUEUE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Free-running clock.
    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Guard against a hung run.
    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

    // Decide whether a side idles this cycle.
    function automatic bit take_gap();
        return !steady_run && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // Apply one request to the behavioural queue and return its response.
    function automatic rsp_t predict_queue_op(input req_t r);
        rsp_t   res;
        entry_t e;
        int     pos;
        res        = '0;
        res.status = STATUS_OK;
        if (r.req_type == REQ_PUSH)
        begin
            if (held_entries.size() >= QUEUE_DEPTH)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                // New entry goes behind every entry of equal or better priority.
                pos = 0;
                while (pos < held_entries.size() && held_entries[pos].prio <= r.item_priority)
                begin
                    pos++;
                end
                e.data = r.item_value;
                e.prio = r.item_priority;
                held_entries.insert(pos, e);
            end
        end
        else
        begin
            if (held_entries.size() == 0)
            begin
                res.status = STATUS_EMPTY;
            end
            else
            begin
                e                   = held_entries.pop_front();
                res.popped_value    = e.data;
                res.popped_priority = e.prio;
            end
        end
        if (held_entries.size() > 0)
        begin
            res.head_value    = held_entries[0].data;
            res.head_priority = held_entries[0].prio;
        end
        else
        begin
            res.queue_empty = 1'b1;
        end
        res.entry_count = COUNT_BITS'(held_entries.size());
        return res;
    endfunction

    function automatic req_t make_req(input logic kind, input logic [31:0] value,
                                      input logic [7:0] prio);
        req_t r;
        r.req_type      = kind;
        r.item_value    = value;
        r.item_priority = prio;
        return r;
    endfunction

    // Send one request transaction, idling at random first.
    task automatic issue_request(input req_t item);
        while (take_gap())
        begin
            req_valid <= 1'b0;
            req       <= make_req(1'($urandom_range(1)), $urandom,
                                  8'($urandom_range(255)));
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        expected_reports.push_back(predict_queue_op(item));
    endtask

    // Stop sending and wait until every predicted response has arrived.
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("%0t: mismatch on %s, expected %0h, got %0h", $realtime, field,
                     want, got);
        end
    endtask

    // Receiver stalls at random.
    always @(posedge clk)
    begin
        rsp_stall <= take_gap();
    end

    // Check each response transaction against the oldest prediction.
    always @(posedge clk)
    begin : check_reports
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("%0t: response with no request outstanding", $realtime);
                end
            end
            else
            begin
                want = expected_reports.pop_front();
                if (rsp.popped_value !== want.popped_value)
                    report_mismatch("popped_value", want.popped_value, rsp.popped_value);
                if (rsp.popped_priority !== want.popped_priority)
                    report_mismatch("popped_priority", want.popped_priority,
                                    rsp.popped_priority);
                if (rsp.status !== want.status)
                    report_mismatch("status", want.status, rsp.status);
                if (rsp.head_value !== want.head_value)
                    report_mismatch("head_value", want.head_value, rsp.head_value);
                if (rsp.head_priority !== want.head_priority)
                    report_mismatch("head_priority", want.head_priority, rsp.head_priority);
                if (rsp.queue_empty !== want.queue_empty)
                    report_mismatch("queue_empty", want.queue_empty, rsp.queue_empty);
                if (rsp.entry_count !== want.entry_count)
                    report_mismatch("entry_count", want.entry_count, rsp.entry_count);
            end
        end
    end

    // Pops on an empty queue, carrying junk in the ignored fields.
    task automatic test_pop_on_empty();
        issue_request(make_req(REQ_POP, 32'hFFFF_FFFF, 8'hFF));
        issue_request(make_req(REQ_POP, 32'h0000_0000, 8'h00));
    endtask

    // Fill the queue with extreme values and runs of equal priority.
    task automatic test_fill_with_extremes();
        issue_request(make_req(REQ_PUSH, 32'h7FFF_FFFF, 8'd255));
        issue_request(make_req(REQ_PUSH, 32'h8000_0000, 8'd0));
        issue_request(make_req(REQ_PUSH, 32'h0000_0000, 8'd128));
        issue_request(make_req(REQ_PUSH, 32'hFFFF_FFFF, 8'd0));
        issue_request(make_req(REQ_PUSH, 32'h0000_0001, 8'd255));
        issue_request(make_req(REQ_PUSH, 32'hAAAA_AAAA, 8'h55));
        issue_request(make_req(REQ_PUSH, 32'h5555_5555, 8'hAA));
        for (int i = 0; i < 9; i++)
        begin
            issue_request(make_req(REQ_PUSH, $urandom, 8'd7));
        end
    endtask

    // Pushes on a full queue, with the lowest and the highest priority value.
    task automatic test_push_on_full();
        issue_request(make_req(REQ_PUSH, 32'h1234_5678, 8'd0));
        issue_request(make_req(REQ_PUSH, 32'h8765_4321, 8'd255));
    endtask

    // Pop a few entries so the head moves through the tied run.
    task automatic test_pop_heads();
        for (int i = 0; i < 4; i++)
        begin
            issue_request(make_req(REQ_POP, $urandom, 8'($urandom_range(255))));
        end
    endtask

    // Random mix whose push bias changes every few dozen transactions, so the
    // fill level swings between empty and full.
    task automatic test_random_traffic(input int count);
        int push_bias;
        push_bias = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       push_bias = 15;
                    1:       push_bias = 50;
                    default: push_bias = 85;
                endcase
            end
            if ($urandom_range(99) < push_bias)
            begin
                // Mostly a narrow priority range, so ties are common.
                if ($urandom_range(99) < 60)
                    issue_request(make_req(REQ_PUSH, $urandom, 8'($urandom_range(3))));
                else
                    issue_request(make_req(REQ_PUSH, $urandom, 8'($urandom_range(255))));
            end
            else
            begin
                issue_request(make_req(REQ_POP, $urandom, 8'($urandom_range(255))));
            end
        end
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_steady_stream(input int count);
        steady_run = 1'b1;
        test_random_traffic(count);
        steady_run = 1'b0;
    endtask

    // Reset, run each test in turn, then report.
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pop_on_empty();
        test_fill_with_extremes();
        test_push_on_full();
        test_pop_heads();
        wait_for_drain();
        test_random_traffic(400);
        test_steady_stream(150);
        test_random_traffic(250);
        wait_for_drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
